// ===== design/tgcq_pkg.sv =====
// Shared types and constants for the tile grid collision query block.
`default_nettype none
package tgcq_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_COORD_BITS  = 16;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_POINT = 2'd1,
    ACT_BOX   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_CELL_WIDTH   = 3'd2,
    CFG_CELL_HEIGHT  = 3'd3,
    CFG_COLUMNS_USED = 3'd4,
    CFG_ROWS_USED    = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_CLAMP,
    ST_SCAN,
    ST_DRAIN,
    ST_WRRD,
    ST_WRWR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== design/tgcq_div.sv =====
// Bit-serial restoring divider: unsigned coordinate offset by an 8-bit tile size.
`default_nettype none
module tgcq_div import tgcq_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [7:0]            divisor,
  output logic [COORD_BITS-1:0] quotient,
  output logic                  busy
);

  localparam int CW = $clog2(COORD_BITS + 1);

  logic [CW-1:0]         cnt;
  logic [7:0]            rem;
  logic [7:0]            dvs;
  logic [COORD_BITS-1:0] q;
  logic [8:0]            trial;
  logic [8:0]            diff;
  logic                  ge;

  assign trial    = {rem, q[COORD_BITS-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(COORD_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[COORD_BITS-2:0], ge};
      rem <= ge ? diff[7:0] : trial[7:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/tgcq_bitmap.sv =====
// Tile bitmap memory, one row per word, with a clearing pass after reset.
`default_nettype none
module tgcq_bitmap import tgcq_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  mem_ctl_t                                      ctl,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wr_addr,
  input  logic [MAX_COLUMNS-1:0]                        wr_data,
  output logic [MAX_COLUMNS-1:0]                        rd_data,
  output logic                                          clearing
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic [AW-1:0]          clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MAX_ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/tile_grid_collision_query_top.sv =====
// Tile grid collision query: tile writes, point and box queries against a solid-tile bitmap.
// Tile write: bitmap row read, then written back, then the result; unknown action: result only.
// Query: bounds check, a miss ends it with no hit; else bit-serial dividers and clamping, and
// an empty clamped span ends it with no hit; else one bitmap row read a cycle over covered rows.
// One item at a time; the next beat is taken once the result sits in the output register.
// After reset the bitmap is cleared one row a cycle, with in_stall high until all rows are clear.
`default_nettype none
module tile_grid_collision_query_top import tgcq_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [5:0]                   cell_column,
  input  logic [5:0]                   cell_row,
  input  logic                         solid,
  input  logic signed [COORD_BITS-1:0] query_left,
  input  logic signed [COORD_BITS-1:0] query_top,
  input  logic signed [COORD_BITS-1:0] query_right,
  input  logic signed [COORD_BITS-1:0] query_bottom,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit
);

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int EW  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam int CB  = COORD_BITS;

  // configuration
  logic signed [CB-1:0] origin_x, origin_y;
  logic [7:0]           cell_width, cell_height;
  logic [6:0]           columns_used, rows_used;

  // latched item
  action_t              act;
  logic [5:0]           col, row;
  logic                 sol;
  logic signed [CB-1:0] ql, qt, qr, qb;

  state_t state, state_next;

  logic signed [EW-1:0] ext_x, ext_y;
  logic                 empty;
  logic                 acc;
  logic                 pend;
  logic [CAW-1:0]       x0r, x1r;
  logic [RAW-1:0]       rowc, y1r;

  logic [6:0]  cols_eff, rows_eff, cm1, rm1;
  logic [14:0] prod_x, prod_y;

  logic signed [EW-1:0] lx, tx, rx, bx, oxe, oye, dl, dt, dr, db;
  logic                 inb_point, inb_box, pass;
  logic [CB-1:0]        dvd_x0, dvd_x1, dvd_y0, dvd_y1;
  logic [CB-1:0]        q_x0, q_x1, q_y0, q_y1, x1c, y1c;
  logic                 bsy_x0, bsy_x1, bsy_y0, bsy_y1, div_busy, span_ok;

  logic                   div_start;
  mem_ctl_t               mctl;
  logic [RAW-1:0]         rd_addr;
  logic [MAX_COLUMNS-1:0] rd_data, wr_data, mask;
  logic                   clearing;
  logic                   wr_in_range;
  logic                   out_free;
  logic                   in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE) || clearing;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      cell_width   <= 8'd8;
      cell_height  <= 8'd8;
      columns_used <= 7'd64;
      rows_used    <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:     origin_x     <= cfg_data;
        CFG_ORIGIN_Y:     origin_y     <= cfg_data;
        CFG_CELL_WIDTH:   cell_width   <= cfg_data[7:0];
        CFG_CELL_HEIGHT:  cell_height  <= cfg_data[7:0];
        CFG_COLUMNS_USED: columns_used <= cfg_data[6:0];
        CFG_ROWS_USED:    rows_used    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign cols_eff = (int'(columns_used) > MAX_COLUMNS) ? 7'(MAX_COLUMNS) : columns_used;
  assign rows_eff = (int'(rows_used) > MAX_ROWS) ? 7'(MAX_ROWS) : rows_used;
  assign cm1      = cols_eff - 7'd1;
  assign rm1      = rows_eff - 7'd1;
  assign prod_x   = 15'(cols_eff) * 15'(cell_width);
  assign prod_y   = 15'(rows_eff) * 15'(cell_height);

  assign lx  = EW'(ql);
  assign tx  = EW'(qt);
  assign rx  = EW'(qr);
  assign bx  = EW'(qb);
  assign oxe = EW'(origin_x);
  assign oye = EW'(origin_y);
  assign dl  = lx - oxe;
  assign dt  = tx - oye;
  assign dr  = rx - oxe - EW'(1);
  assign db  = bx - oye - EW'(1);

  assign inb_point = (lx >= oxe) && (tx >= oye) && (lx < ext_x) && (tx < ext_y);
  assign inb_box   = (lx < ext_x) && (rx > oxe) && (tx < ext_y) && (bx > oye);
  assign pass      = !empty && ((act == ACT_POINT) ? inb_point : inb_box);

  // left and top below the origin clamp to tile zero
  assign dvd_x0 = (dl < 0) ? '0 : CB'(dl);
  assign dvd_y0 = (dt < 0) ? '0 : CB'(dt);
  assign dvd_x1 = (act == ACT_POINT) ? CB'(dl) : CB'(dr);
  assign dvd_y1 = (act == ACT_POINT) ? CB'(dt) : CB'(db);

  tgcq_div #(.COORD_BITS(CB)) u_div_x0 (
    .clk, .rst, .start(div_start), .dividend(dvd_x0), .divisor(cell_width),
    .quotient(q_x0), .busy(bsy_x0));
  tgcq_div #(.COORD_BITS(CB)) u_div_x1 (
    .clk, .rst, .start(div_start), .dividend(dvd_x1), .divisor(cell_width),
    .quotient(q_x1), .busy(bsy_x1));
  tgcq_div #(.COORD_BITS(CB)) u_div_y0 (
    .clk, .rst, .start(div_start), .dividend(dvd_y0), .divisor(cell_height),
    .quotient(q_y0), .busy(bsy_y0));
  tgcq_div #(.COORD_BITS(CB)) u_div_y1 (
    .clk, .rst, .start(div_start), .dividend(dvd_y1), .divisor(cell_height),
    .quotient(q_y1), .busy(bsy_y1));

  assign div_busy = bsy_x0 || bsy_x1 || bsy_y0 || bsy_y1;
  assign x1c      = (q_x1 > CB'(cm1)) ? CB'(cm1) : q_x1;
  assign y1c      = (q_y1 > CB'(rm1)) ? CB'(rm1) : q_y1;
  assign span_ok  = (q_x0 <= x1c) && (q_y0 <= y1c);

  assign wr_in_range = (int'(col) < MAX_COLUMNS) && (int'(row) < MAX_ROWS);

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      mask[c]    = (int'(x0r) <= c) && (c <= int'(x1r));
      wr_data[c] = (c == int'(col)) ? sol : rd_data[c];
    end
  end

  tgcq_bitmap #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_bitmap (
    .clk, .rst, .ctl(mctl), .rd_addr, .wr_addr(RAW'(row)), .wr_data,
    .rd_data, .clearing);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_t'(action))
            ACT_WRITE: state_next = ST_WRRD;
            ACT_POINT: state_next = ST_PREP;
            ACT_BOX:   state_next = ST_PREP;
            default:   state_next = ST_FIN;
          endcase
        end
      end
      ST_PREP:  state_next = ST_CHECK;
      ST_CHECK: state_next = pass ? ST_DIV : ST_FIN;
      ST_DIV:   state_next = div_busy ? ST_DIV : ST_CLAMP;
      ST_CLAMP: state_next = span_ok ? ST_SCAN : ST_FIN;
      ST_SCAN:  state_next = (rowc == y1r) ? ST_DRAIN : ST_SCAN;
      ST_DRAIN: state_next = ST_FIN;
      ST_WRRD:  state_next = ST_WRWR;
      ST_WRWR:  state_next = ST_FIN;
      ST_FIN:   state_next = out_free ? ST_IDLE : ST_FIN;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start   = 1'b0;
    mctl.rd_en  = 1'b0;
    mctl.wr_en  = 1'b0;
    rd_addr     = rowc;
    case (state)
      ST_CHECK: div_start = pass;
      ST_SCAN:  mctl.rd_en = 1'b1;
      ST_WRRD: begin
        mctl.rd_en = wr_in_range;
        rd_addr    = RAW'(row);
      end
      ST_WRWR:  mctl.wr_en = wr_in_range;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_SCAN);
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act <= action_t'(action);
      col <= cell_column;
      row <= cell_row;
      sol <= solid;
      ql  <= query_left;
      qt  <= query_top;
      qr  <= query_right;
      qb  <= query_bottom;
      acc <= 1'b0;
    end else if (pend) begin
      acc <= acc | (|(rd_data & mask));
    end
    if (state == ST_PREP) begin
      ext_x <= oxe + EW'(prod_x);
      ext_y <= oye + EW'(prod_y);
      empty <= (cell_width == 8'd0) || (cell_height == 8'd0) ||
               (cols_eff == 7'd0) || (rows_eff == 7'd0);
    end
    if (state == ST_CLAMP) begin
      x0r  <= CAW'(q_x0);
      x1r  <= CAW'(x1c);
      rowc <= RAW'(q_y0);
      y1r  <= RAW'(y1c);
    end else if (state == ST_SCAN) begin
      rowc <= rowc + 1'b1;
    end
    if (state == ST_FIN && out_free) begin
      hit <= acc;
    end
  end

endmodule
`default_nettype wire

// ===== design/tgcq_checker.sv =====
// Port-level checks for the tile grid collision query block, bound to the top level.
`default_nettype none
module tgcq_props (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire hit
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && in_stall)
    else $error("output or input side live straight after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while an item is in flight");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit))
    else $error("stalled result dropped or changed");

endmodule

bind tile_grid_collision_query_top tgcq_props u_tgcq_props (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .hit);
`default_nettype wire

// ===== sim/tgcq_checker.sv =====
// Checker for the tile grid collision query block: predicts hit per input beat and compares.
`timescale 1ns / 1ps
module tgcq_checker import tgcq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         action,
  input  logic [5:0]         cell_column,
  input  logic [5:0]         cell_row,
  input  logic               solid,
  input  logic signed [15:0] query_left,
  input  logic signed [15:0] query_top,
  input  logic signed [15:0] query_right,
  input  logic signed [15:0] query_bottom,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               hit,
  output int                 fail_count,
  output int                 pending,
  output int                 hits_seen
);
  longint gx, gy, cw, ch, ncol, nrow;
  logic [63:0] tiles [64];
  bit hit_queue [$];

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic bit point_hit(longint px, longint py);
    longint c, r;
    c = ncol > 64 ? 64 : ncol;
    r = nrow > 64 ? 64 : nrow;
    if (cw == 0 || ch == 0 || c == 0 || r == 0) return 0;
    if (px < gx || py < gy || px >= gx + c * cw || py >= gy + r * ch) return 0;
    return tiles[(py - gy) / ch][(px - gx) / cw];
  endfunction

  function automatic bit box_hit(longint l, longint t, longint rt, longint b);
    longint c, r, x0, y0, x1, y1;
    logic [63:0] m;
    c = ncol > 64 ? 64 : ncol;
    r = nrow > 64 ? 64 : nrow;
    if (cw == 0 || ch == 0 || c == 0 || r == 0) return 0;
    if (!(l < gx + c * cw && rt > gx && t < gy + r * ch && b > gy)) return 0;
    x0 = fdiv(l - gx, cw);
    y0 = fdiv(t - gy, ch);
    x1 = fdiv(rt - gx - 1, cw);
    y1 = fdiv(b - gy - 1, ch);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > c - 1) x1 = c - 1;
    if (y1 > r - 1) y1 = r - 1;
    if (x1 < x0 || y1 < y0) return 0;
    m = '0;
    for (longint i = x0; i <= x1; i++) m[i] = 1'b1;
    for (longint j = y0; j <= y1; j++)
      if ((tiles[j] & m) != 0) return 1;
    return 0;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    bit exp_hit;
    if (rst) begin
      gx = 0; gy = 0; cw = 8; ch = 8; ncol = 64; nrow = 64;
      foreach (tiles[i]) tiles[i] = '0;
      hit_queue.delete();
      fail_count = 0;
      hits_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_X:     gx = longint'($signed(cfg_data));
          CFG_ORIGIN_Y:     gy = longint'($signed(cfg_data));
          CFG_CELL_WIDTH:   cw = cfg_data[7:0];
          CFG_CELL_HEIGHT:  ch = cfg_data[7:0];
          CFG_COLUMNS_USED: ncol = cfg_data[6:0];
          CFG_ROWS_USED:    nrow = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (hit_queue.size() == 0) report("result beat with nothing expected");
        else begin
          exp_hit = hit_queue.pop_front();
          if (hit !== exp_hit)
            report($sformatf("hit got %b want %b", hit, exp_hit));
          if (exp_hit) hits_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        exp_hit = 0;
        case (action)
          ACT_WRITE: tiles[cell_row][cell_column] = solid;
          ACT_POINT: exp_hit = point_hit(query_left, query_top);
          ACT_BOX:   exp_hit = box_hit(query_left, query_top, query_right, query_bottom);
          default: ;
        endcase
        hit_queue.push_back(exp_hit);
      end
    end
    pending = hit_queue.size();
  end
endmodule

// ===== sim/testbench.sv =====
// Top of the tile grid collision query testbench: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module testbench import tgcq_pkg::*;;
  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [1:0] action = '0;
  logic [5:0] cell_column = '0, cell_row = '0;
  logic solid = 0;
  logic signed [15:0] query_left = '0, query_top = '0, query_right = '0, query_bottom = '0;
  logic out_valid, out_stall = 0, hit;
  int fail_count, pending, hits_seen;
  bit calm = 0;
  int n_items = 0;
  logic [7:0] cur_cw = 8, cur_ch = 8;
  logic signed [15:0] cur_gx = 0, cur_gy = 0;
  logic [6:0] cur_nc = 64, cur_nr = 64;

  always #5 clk = ~clk;

  tile_grid_collision_query_top dut (.*);
  tgcq_checker chk (.*);

  initial begin
    int stretch;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        stretch = $urandom_range(1, 8);
        out_stall <= 1;
        repeat (stretch) @(posedge clk);
      end
      out_stall <= 0;
    end
  end

  // cfg_valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic grid_setup(logic signed [15:0] ox, logic signed [15:0] oy, logic [7:0] w,
                            logic [7:0] h, logic [6:0] nc, logic [6:0] nr);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_CELL_WIDTH, {8'd0, w});
    write_reg(CFG_CELL_HEIGHT, {8'd0, h});
    write_reg(CFG_COLUMNS_USED, {9'd0, nc});
    write_reg(CFG_ROWS_USED, {9'd0, nr});
    cfg_valid <= 0;
    cur_gx = ox; cur_gy = oy; cur_cw = w; cur_ch = h; cur_nc = nc; cur_nr = nr;
  endtask

  // in_valid stays high into the next beat; idle gaps and phase ends drop it
  task automatic send(logic [1:0] a, logic [5:0] c, logic [5:0] r, logic s,
                      logic signed [15:0] l, logic signed [15:0] t,
                      logic signed [15:0] rt, logic signed [15:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    action <= a; cell_column <= c; cell_row <= r; solid <= s;
    query_left <= l; query_top <= t; query_right <= rt; query_bottom <= b;
    do @(posedge clk); while (in_stall);
    n_items++;
  endtask

  function automatic logic signed [15:0] near_x();
    int span;
    span = int'(cur_nc) * int'(cur_cw);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(int'(cur_gx) + $urandom_range(0, span + 40) - 20);
  endfunction

  function automatic logic signed [15:0] near_y();
    int span;
    span = int'(cur_nr) * int'(cur_ch);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(int'(cur_gy) + $urandom_range(0, span + 40) - 20);
  endfunction

  task automatic random_run(int count);
    logic signed [15:0] l, t;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      l = near_x();
      t = near_y();
      if (k < 7)
        send(ACT_WRITE, 6'($urandom), 6'($urandom), $urandom_range(0, 3) != 0,
             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (k < 11)
        send(ACT_POINT, 6'($urandom), 6'($urandom), 1'($urandom), l, t,
             16'($urandom), 16'($urandom));
      else if (k < 19)
        send(ACT_BOX, 6'($urandom), 6'($urandom), 1'($urandom), l, t,
             16'(l + $urandom_range(0, 60) - 4), 16'(t + $urandom_range(0, 60) - 4));
      else
        send(ACT_NONE, 6'($urandom), 6'($urandom), 1'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: defaults, corner tiles, edges, extremes, unknown action
    send(ACT_WRITE, 0, 0, 1, 0, 0, 0, 0);
    send(ACT_WRITE, 63, 63, 1, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_POINT, 0, 0, 0, 511, 511, 0, 0);
    send(ACT_POINT, 0, 0, 0, 512, 511, 0, 0);
    send(ACT_POINT, 0, 0, 0, -1, 0, 0, 0);
    send(ACT_BOX, 0, 0, 0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send(ACT_BOX, 0, 0, 0, -8, -8, 0, 0);
    send(ACT_BOX, 0, 0, 0, -8, -8, 1, 1);
    send(ACT_BOX, 0, 0, 0, 512, 504, 600, 600);
    send(ACT_BOX, 0, 0, 0, 511, 511, 512, 512);
    send(ACT_BOX, 0, 0, 0, 20, 20, 10, 30);
    send(ACT_BOX, 0, 0, 0, 0, 0, 0, 8);
    send(ACT_NONE, 63, 63, 1, 0, 0, 100, 100);
    send(ACT_POINT, 63, 63, 1, 505, 505, 0, 0);
    send(ACT_WRITE, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_POINT, 0, 0, 0, 1, 1, 0, 0);
    random_run(60);
    grid_setup(-16'sd32768, 16'sd32767, 255, 255, 1, 1);
    send(ACT_POINT, 0, 0, 0, -16'sd32768, 16'sd32767, 0, 0);
    send(ACT_BOX, 0, 0, 0, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
    random_run(40);
    grid_setup(16'sd32767, -16'sd32768, 1, 1, 64, 64);
    random_run(60);
    grid_setup(-100, -50, 3, 5, 127, 127);
    random_run(80);
    grid_setup(10, 20, 1, 255, 17, 9);
    random_run(60);
    grid_setup(-16'sd20000, 16'sd1234, 7, 2, 40, 64);
    random_run(60);
    calm = 1;
    grid_setup(0, 0, 8, 8, 64, 64);
    random_run(60);
    in_valid <= 0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    $display("ran %0d input items over seven grid settings; %0d hits seen", n_items,
             hits_seen);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== sim.f =====
design/tgcq_pkg.sv
design/tgcq_div.sv
design/tgcq_bitmap.sv
design/tile_grid_collision_query_top.sv
design/tgcq_checker.sv
sim/tgcq_checker.sv
sim/testbench.sv
